// ----- src/ttt_pkg.sv -----
package ttt_pkg;

    // Table geometry.
    localparam int MAX_TIMERS  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDXW  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNTW  = $clog2(MAX_TIMERS + 1);
    localparam int FIREW = $clog2(MAX_RESULTS + 1);

    // Item kinds.
    localparam logic [1:0] KIND_SCHEDULE = 2'd0;
    localparam logic [1:0] KIND_KILL     = 2'd1;
    localparam logic [1:0] KIND_TICK     = 2'd2;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ID    = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] timer_id;
        logic [31:0] delay_ticks;
        logic        periodic;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        fire;
        logic [15:0] fired_id;
        logic        last;
    } t_out_item;

    // One stored timer.
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] delay;
        logic [31:0] elapsed;
        logic        periodic;
    } t_entry;

    // Outcome of evaluating one entry against the current transaction.
    typedef struct packed {
        logic   keep;
        logic   match;
        logic   fire;
        t_entry entry;
    } t_eval;

endpackage

// ----- src/ttt_ram.sv -----
module ttt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ttt_eval.sv -----
module ttt_eval
    import ttt_pkg::*;
(
    input  t_in_item i_item,
    input  t_entry   i_entry,
    output t_eval    o_res
);

    logic [31:0] elapsed_inc;
    logic        id_match;

    // Saturating tick count and id compare for the entry under evaluation.
    assign elapsed_inc = (i_entry.elapsed == '1) ? i_entry.elapsed
                                                 : i_entry.elapsed + 32'd1;
    assign id_match = (i_entry.id == i_item.timer_id);

    always_comb begin
        o_res.keep  = 1'b1;
        o_res.match = id_match;
        o_res.fire  = 1'b0;
        o_res.entry = i_entry;
        unique case (i_item.kind)
            KIND_SCHEDULE: begin
                // A matching entry is replaced in place, or dropped on zero delay.
                if (id_match) begin
                    if (i_item.delay_ticks == 32'd0) begin
                        o_res.keep = 1'b0;
                    end else begin
                        o_res.entry.delay    = i_item.delay_ticks;
                        o_res.entry.elapsed  = 32'd0;
                        o_res.entry.periodic = i_item.periodic;
                    end
                end
            end
            KIND_KILL: begin
                o_res.keep = !id_match;
            end
            KIND_TICK: begin
                // Expired one-shot entries drop out; periodic ones restart.
                o_res.fire = (elapsed_inc >= i_entry.delay);
                o_res.keep = !o_res.fire || i_entry.periodic;
                o_res.entry.elapsed = o_res.fire ? 32'd0 : elapsed_inc;
            end
            default: begin
                o_res.keep = 1'b1;
            end
        endcase
    end

endmodule

// ----- src/tick_timer_table_core.sv -----
// Timer table with up to MAX_TIMERS entries, kept packed in table order.
// Input channel (i_in_valid / o_in_stall / i_in_item): one transaction is a
// schedule, kill or tick command. Output channel (o_out_valid / i_out_stall /
// o_out_item): result transactions; the final result of each command has last set.
// A schedule or kill gives one result; a tick gives one result per expired
// timer in table order (at most MAX_RESULTS), or a single no-fire result.
// Each command walks the whole table through one shared entry evaluator and
// a single-port-read table RAM, one entry per cycle unless a held fire result
// stalls it, compacting removed entries as it goes. A schedule or kill with
// id zero, an unused kind, or any command on an empty table skips the walk
// and goes straight to its final result. o_in_stall is high for the
// whole walk. The output register lets the next command start while the
// previous result is still waiting. A tick that finds a second expired timer
// while its earlier fire result cannot leave yet holds the walk until the
// output register frees up. Reset empties the table and drops any pending
// output; the table contents themselves are not cleared.
module tick_timer_table_core
    import ttt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } t_state;

    t_state    r_state,      n_state;
    t_in_item  r_item,       n_item;
    logic [CNTW-1:0]  r_count, n_count;
    logic [IDXW-1:0]  r_rd,    n_rd;
    logic [CNTW-1:0]  r_wr,    n_wr;
    logic             r_found, n_found;
    logic             r_pend_valid, n_pend_valid;
    logic [15:0]      r_pend_id,    n_pend_id;
    logic [FIREW-1:0] r_fires,      n_fires;
    logic             r_out_valid,  n_out_valid;
    t_out_item        r_out,        n_out;

    logic             ram_we;
    logic             ram_re;
    logic [IDXW-1:0]  ram_waddr;
    logic [IDXW-1:0]  ram_raddr;
    t_entry           ram_wdata;
    t_entry           ram_rdata;
    t_eval            ev;

    logic             accept;
    logic             can_push;
    logic             in_direct;
    logic             item_direct;
    logic             fire_rep;
    logic             hold;
    logic             walk_last;

    ttt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ttt_eval u_eval (
        .i_item  (r_item),
        .i_entry (ram_rdata),
        .o_res   (ev)
    );

    // Handshake terms.
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign can_push = !r_out_valid || !i_out_stall;

    // Commands answered without walking the table.
    assign in_direct = (i_in_item.kind == KIND_UNUSED) ||
                       ((i_in_item.kind != KIND_TICK) && (i_in_item.timer_id == 16'd0));
    assign item_direct = (r_item.kind == KIND_UNUSED) ||
                         ((r_item.kind != KIND_TICK) && (r_item.timer_id == 16'd0));

    // Walk control for the entry whose data sits in the RAM output register.
    assign fire_rep  = (r_item.kind == KIND_TICK) && ev.fire &&
                       (r_fires < FIREW'(MAX_RESULTS));
    assign hold      = fire_rep && r_pend_valid && !can_push;
    assign walk_last = ((CNTW'(r_rd) + CNTW'(1)) == r_count);

    // Sequencer next-state logic.
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_count      = r_count;
        n_rd         = r_rd;
        n_wr         = r_wr;
        n_found      = r_found;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_fires      = r_fires;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = r_wr[IDXW-1:0];
        ram_raddr    = r_rd;
        ram_wdata    = ev.entry;

        unique case (r_state)
            S_IDLE: begin
                // Take a command and, unless it is answered directly or the table is empty, start reading entry zero.
                if (accept) begin
                    n_item       = i_in_item;
                    n_rd         = '0;
                    n_wr         = '0;
                    n_found      = 1'b0;
                    n_pend_valid = 1'b0;
                    n_fires      = '0;
                    if (in_direct || (r_count == '0)) begin
                        n_state = S_FINISH;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_state   = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // Evaluate one entry, write it back compacted if kept, fetch the next; all wait while held.
                if (!hold) begin
                    if (ev.keep) begin
                        ram_we = 1'b1;
                        n_wr   = r_wr + CNTW'(1);
                    end
                    if (ev.match) begin
                        n_found = 1'b1;
                    end
                    if (fire_rep) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = '{status: ST_OK, fire: 1'b1,
                                            fired_id: r_pend_id, last: 1'b0};
                        end
                        n_pend_valid = 1'b1;
                        n_pend_id    = ram_rdata.id;
                        n_fires      = r_fires + FIREW'(1);
                    end
                    if (walk_last) begin
                        n_state = S_FINISH;
                    end else begin
                        n_rd      = r_rd + IDXW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = r_rd + IDXW'(1);
                    end
                end
            end
            S_FINISH: begin
                // Final result, plus the append of a new schedule entry.
                if (can_push) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_OK, fire: 1'b0, fired_id: 16'd0,
                                    last: 1'b1};
                    n_count     = item_direct ? r_count : r_wr;
                    n_state     = S_IDLE;
                    if (item_direct) begin
                        if (r_item.kind != KIND_UNUSED) begin
                            n_out.status = ST_BAD_ID;
                        end
                    end else begin
                        unique case (r_item.kind)
                            KIND_SCHEDULE: begin
                                if (r_item.delay_ticks == 32'd0) begin
                                    n_out.fire     = 1'b1;
                                    n_out.fired_id = r_item.timer_id;
                                end else if (!r_found) begin
                                    if (r_wr == CNTW'(MAX_TIMERS)) begin
                                        n_out.status = ST_FULL;
                                    end else begin
                                        ram_we    = 1'b1;
                                        ram_wdata = '{id: r_item.timer_id,
                                                      delay: r_item.delay_ticks,
                                                      elapsed: 32'd0,
                                                      periodic: r_item.periodic};
                                        n_count   = r_wr + CNTW'(1);
                                    end
                                end
                            end
                            KIND_KILL: begin
                                if (!r_found) begin
                                    n_out.status = ST_NOT_FOUND;
                                end
                            end
                            KIND_TICK: begin
                                if (r_pend_valid) begin
                                    n_out.fire     = 1'b1;
                                    n_out.fired_id = r_pend_id;
                                end
                            end
                            default: begin
                                n_out.status = ST_OK;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_rd      <= n_rd;
        r_wr      <= n_wr;
        r_found   <= n_found;
        r_pend_id <= n_pend_id;
        r_fires   <= n_fires;
        r_out     <= n_out;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The fill count never passes the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_TIMERS))
        else $error("timer count exceeds table size");

    // Compaction writes never run ahead of the read pointer.
    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_wr <= CNTW'(r_rd)))
        else $error("write index passed read index");

    // The table is only written while a command is being processed.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("table written while idle");

    // A result that reports no expiry carries a zero id.
    a_fire_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.fire || (r_out.fired_id == 16'd0)))
        else $error("nonzero id on a non-fire result");

    // A held fire result implies the walk is paused with a full output register.
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) && hold) |=> (r_state == S_WALK))
        else $error("walk left while a fire result was held");

endmodule
